[src/elba_pkg.sv]
// ----------------------------------------------------------------------------
// elba_pkg
// Shared widths, constants and register map for the echo level batch alarm.
// ----------------------------------------------------------------------------
package elba_pkg;

	localparam int ECHO_W     = 15;
	localparam int LEVEL_W    = 16;
	localparam int SLOT_OUT_W = 3;

	// distance in 1/256 cm = (echo_us * DIST_MUL) >> DIST_SHIFT
	localparam int DIST_MUL_W = 11;
	localparam int DIST_SHIFT = 8;
	localparam int DIST_PROD_W = ECHO_W + DIST_MUL_W;
	localparam int DIST_W     = DIST_PROD_W - DIST_SHIFT;
	localparam logic [DIST_MUL_W-1:0] DIST_MUL = 11'd1124;

	localparam int WINDOW_LEN_DEF = 5;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	localparam logic [ECHO_W-1:0]  MIN_ECHO_RST  = 15'd58;
	localparam logic [ECHO_W-1:0]  MAX_ECHO_RST  = 15'd4000;
	localparam logic [LEVEL_W-1:0] HEIGHT_RST    = 16'd6400;
	localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 16'd3840;

	typedef enum logic [1:0] {
		REG_MIN_ECHO  = 2'd0,
		REG_MAX_ECHO  = 2'd1,
		REG_HEIGHT    = 2'd2,
		REG_THRESHOLD = 2'd3
	} reg_idx_t;

endpackage

[src/echo_level_batch_alarm.sv]
// ----------------------------------------------------------------------------
// echo_level_batch_alarm
// Median-of-three echo filter, water level, batch average and flood alarm.
// ----------------------------------------------------------------------------
// channel   direction  protocol        content
// s_*       in         tvalid/tready   three echo durations per transaction
// m_*       out        tvalid/tready   level, batch status, average, alarm
// p*        in/out     APB, 32 bit     four configuration registers
//
// Four-stage pipeline: input register, median and distance, level and batch
// accumulate, then average, alarm and output register. One transaction per
// cycle unless m_tready stalls the pipeline.
// Each stage holds while the stage after it is full and stalled, so bubbles
// are squeezed out and input is taken while a result waits on m_tready.
// arst_n clears the pipeline, batch sum, slot count and alarm, and resets the registers.
// ----------------------------------------------------------------------------
module echo_level_batch_alarm
	import elba_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// s_tdata: [14:0] echo_a, [29:15] echo_b, [44:30] echo_c, [47:45] zero
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// m_tdata: [0] reading_ok, [16:1] water_level, [19:17] slots_filled,
	//          [20] batch_done, [36:21] batch_average, [37] alarm_on, [39:38] zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int L_W     = $clog2(WINDOW_LEN);
	localparam int SUM_W   = LEVEL_W + L_W;
	localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
	localparam int SHIFT   = SUM_W + L_W;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_LEN);
	localparam logic [SUM_W-1:0] WIN_SUM  = SUM_W'(WINDOW_LEN);

	// configuration
	logic [ECHO_W-1:0]  min_echo_q;
	logic [ECHO_W-1:0]  max_echo_q;
	logic [LEVEL_W-1:0] height_q;
	logic [LEVEL_W-1:0] threshold_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_echo_q  <= MIN_ECHO_RST;
			max_echo_q  <= MAX_ECHO_RST;
			height_q    <= HEIGHT_RST;
			threshold_q <= THRESHOLD_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MIN_ECHO:  min_echo_q  <= pwdata[ECHO_W-1:0];
				REG_MAX_ECHO:  max_echo_q  <= pwdata[ECHO_W-1:0];
				REG_HEIGHT:    height_q    <= pwdata[LEVEL_W-1:0];
				REG_THRESHOLD: threshold_q <= pwdata[LEVEL_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_MIN_ECHO:  prdata = APB_DATA_W'(min_echo_q);
			REG_MAX_ECHO:  prdata = APB_DATA_W'(max_echo_q);
			REG_HEIGHT:    prdata = APB_DATA_W'(height_q);
			REG_THRESHOLD: prdata = APB_DATA_W'(threshold_q);
		endcase
	end

	// pipeline handshake
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !v_s4 || m_tready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;
	assign m_tvalid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// stage 1: input register
	logic [ECHO_W-1:0] echo_a_s1, echo_b_s1, echo_c_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			echo_a_s1 <= s_tdata[ECHO_W-1:0];
			echo_b_s1 <= s_tdata[2*ECHO_W-1:ECHO_W];
			echo_c_s1 <= s_tdata[3*ECHO_W-1:2*ECHO_W];
		end
	end

	// stage 2: validity, median, distance
	// invalid shots become all ones, so with two valid the median is the larger
	logic                   ok_a, ok_b, ok_c, ok_rd;
	logic [ECHO_W-1:0]      ea, eb, ec, lo_ab, hi_ab, med;
	logic [DIST_PROD_W-1:0] dist_prod;
	logic                   ok_s2;
	logic [DIST_W-1:0]      dist_s2;

	always_comb begin
		ok_a  = (echo_a_s1 != '0) && (echo_a_s1 >= min_echo_q) && (echo_a_s1 <= max_echo_q);
		ok_b  = (echo_b_s1 != '0) && (echo_b_s1 >= min_echo_q) && (echo_b_s1 <= max_echo_q);
		ok_c  = (echo_c_s1 != '0) && (echo_c_s1 >= min_echo_q) && (echo_c_s1 <= max_echo_q);
		ok_rd = (ok_a && ok_b) || (ok_a && ok_c) || (ok_b && ok_c);
		ea    = ok_a ? echo_a_s1 : '1;
		eb    = ok_b ? echo_b_s1 : '1;
		ec    = ok_c ? echo_c_s1 : '1;
		lo_ab = (ea < eb) ? ea : eb;
		hi_ab = (ea < eb) ? eb : ea;
		med   = (hi_ab < ec) ? hi_ab : ((lo_ab > ec) ? lo_ab : ec);
		dist_prod = DIST_PROD_W'(med) * DIST_PROD_W'(DIST_MUL);
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			ok_s2   <= ok_rd;
			dist_s2 <= dist_prod[DIST_SHIFT +: DIST_W];
		end
	end

	// stage 3: level and batch accumulate
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [LEVEL_W-1:0] level;
	logic [SUM_W-1:0]   total;
	logic [CNT_W-1:0]   cnt_nxt;
	logic               last;
	logic               adv2;

	logic                  ok_s3;
	logic [LEVEL_W-1:0]    level_s3;
	logic [SLOT_OUT_W-1:0] slots_s3;
	logic                  done_s3;
	logic [SUM_W-1:0]      total_s3;

	assign adv2 = rdy3 && v_s2;

	always_comb begin
		level   = (dist_s2 >= DIST_W'(height_q)) ? '0 :
			LEVEL_W'(DIST_W'(height_q) - dist_s2);
		total   = sum_q + SUM_W'(level);
		cnt_nxt = cnt_q + CNT_W'(1);
		last    = (cnt_nxt == CNT_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (adv2 && ok_s2) begin
			sum_q <= last ? '0 : total;
			cnt_q <= last ? '0 : cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			ok_s3    <= ok_s2;
			level_s3 <= ok_s2 ? level : '0;
			slots_s3 <= ok_s2 ? SLOT_OUT_W'(cnt_nxt) : SLOT_OUT_W'(cnt_q);
			done_s3  <= ok_s2 && last;
			total_s3 <= total;
		end
	end

	// stage 4: average by reciprocal, alarm, output register
	logic [PROD_W-1:0]  avg_prod;
	logic [SUM_W-1:0]   thr_sum;
	logic               alarm_q;
	logic               alarm_nxt;
	logic [LEVEL_W-1:0] avg;
	logic               adv3;

	assign adv3 = rdy4 && v_s3;

	always_comb begin
		avg_prod  = PROD_W'(total_s3) * PROD_W'(RECIP);
		thr_sum   = WIN_SUM * SUM_W'(threshold_q);
		avg       = done_s3 ? avg_prod[SHIFT +: LEVEL_W] : '0;
		alarm_nxt = done_s3 ? (total_s3 >= thr_sum) : alarm_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q <= 1'b0;
		end else if (adv3) begin
			alarm_q <= alarm_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			m_tdata <= {2'b00, alarm_nxt, avg, done_s3, slots_s3, level_s3, ok_s3};
		end
	end

endmodule
